[hdl/voxel_face_culling_mesher_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the voxel face-culling mesher.
// Each macro expects signals named clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULLING_MESHER_CORE_MACROS_SVH
`define VOXEL_FACE_CULLING_MESHER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VFCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfcm same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define VFCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfcm next-cycle check failed");

`endif

[hdl/vfcm_pkg.sv]
// ---------------------------------------------------------------------------
// vfcm_pkg
// Field widths, operation codes, register indexes and sequencer states that
// the mesher core and its port checker share.
// ---------------------------------------------------------------------------
package vfcm_pkg;

  // Field widths of the command and face transfers.
  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 5;
  localparam int CIDX_W     = 8;
  localparam int SLOT_W     = 8;
  localparam int RGBA_W     = 32;
  localparam int POS_W      = 9;
  localparam int FY_W       = 5;
  localparam int DIR_W      = 3;
  localparam int CH_W       = 8;
  localparam int RGB_W      = 24;
  localparam int VTX_W      = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int FACES      = 6;

  // Operation codes carried by func.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_EMIT   = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_PAL = 2'd2;

  // Face directions at the ends of the walk.
  localparam logic [DIR_W-1:0] FACE_PX = 3'd0;
  localparam logic [DIR_W-1:0] FACE_NZ = 3'd5;

  // Axis that a direction steps along (direction divided by two).
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_H = 2'd1;
  localparam logic [1:0] AXIS_Y = 2'd2;

  // Reset values and fixed constants.
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd32;
  localparam logic [RGB_W-1:0]      WHITE      = 24'hFFFFFF;
  localparam logic [VTX_W-1:0]      VTX_STEP   = 24'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR  = 3'd0,
    ST_IDLE   = 3'd1,
    ST_LOOK   = 3'd2,
    ST_GATHER = 3'd3,
    ST_EMIT   = 3'd4
  } state_t;

endpackage

[hdl/voxel_face_culling_mesher_core.sv]
// ---------------------------------------------------------------------------
// voxel_face_culling_mesher_core: face-culling voxel mesher, one command at a time.
// Load, insert and an emit of an out-of-grid cell finish when taken; an emit of an empty
// cell passes through the look state only. An emit of a present cell makes seven occupancy
// RAM reads, the cell and its six neighbours through one neighbour unit, then holds busy
// while it sends one face per open face.
// Clear and reset sweep all 2**(3*clog2(GRID_SIDE)) occupancy RAM entries, one entry a cycle.
// ---------------------------------------------------------------------------
module voxel_face_culling_mesher_core #(
  parameter int GRID_SIDE       = 32,
  parameter int PALETTE_ENTRIES = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  // Command transfer
  input  logic                                start,
  output logic                                busy,
  input  logic [vfcm_pkg::FUNC_W-1:0]         func,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_x,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_y,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_h,
  input  logic [vfcm_pkg::CIDX_W-1:0]         color_index,
  input  logic [vfcm_pkg::SLOT_W-1:0]         palette_slot,
  input  logic [vfcm_pkg::RGBA_W-1:0]         palette_rgba,
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vfcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Face results
  output logic                                strobe,
  output logic signed [vfcm_pkg::POS_W-1:0]   face_x,
  output logic [vfcm_pkg::FY_W-1:0]           face_y,
  output logic signed [vfcm_pkg::POS_W-1:0]   face_z,
  output logic [vfcm_pkg::DIR_W-1:0]          face_dir,
  output logic [vfcm_pkg::CH_W-1:0]           red,
  output logic [vfcm_pkg::CH_W-1:0]           green,
  output logic [vfcm_pkg::CH_W-1:0]           blue,
  output logic [vfcm_pkg::VTX_W-1:0]          base_vertex,
  output logic                                last_face
);
  import vfcm_pkg::*;

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0]    GRID_LIM = 9'(GRID_SIDE);
  localparam logic [8:0]    PAL_LIM  = 9'(PALETTE_ENTRIES);
  localparam logic [CW-1:0] H_TOP    = CW'(GRID_SIDE - 1);
  localparam logic [AW-1:0] CLR_LAST = {AW{1'b1}};

  // Configuration registers
  logic [CFG_DATA_W-1:0] model_size_x;
  logic [CFG_DATA_W-1:0] model_size_y;
  logic                  has_palette;

  // Sequencer and block state
  state_t          state, state_next;
  logic [AW-1:0]   clr_addr;
  logic [CW-1:0]   least;
  logic [VTX_W-1:0] vcount;
  logic [CW-1:0]   cx, cy, ch;
  logic [DIR_W-1:0] dir;
  logic [FACES-1:0] face_mask;
  logic            nb_out;
  logic            use_pal;

  // Memories
  logic [CIDX_W:0]  occ_mem [DEPTH];
  logic [CIDX_W:0]  occ_rd;
  logic [RGB_W-1:0] pal_mem [PALETTE_ENTRIES];
  logic [RGB_W-1:0] pal_rd;

  // Decoded command
  logic          accept;
  logic [7:0]    x_ext, y_ext, h_ext;
  logic [CW-1:0] x_in, y_in, h_in;
  logic          inside_in;
  logic [AW-1:0] own_addr;

  // Controls from the sequencer
  logic in_clear, in_look, in_gather, in_emit;

  // Neighbour unit
  logic [DIR_W-1:0] issue_dir;
  logic [1:0]       axis;
  logic [CW-1:0]    nb_sel;
  logic [8:0]       nb_sum;
  logic             nb_outside;
  logic [AW-1:0]    nb_addr;

  // Memory ports
  logic             occ_we;
  logic [AW-1:0]    occ_waddr;
  logic [CIDX_W:0]  occ_wdata;
  logic [AW-1:0]    occ_raddr;
  logic [CIDX_W-1:0] cidx_m1;
  logic             pal_hit;
  logic             pal_we;

  // Face walk
  logic [DIR_W-1:0] pick;
  logic [FACES-1:0] pick_oh;
  logic [FACES-1:0] rest;
  logic             emit_fire;
  logic [POS_W-1:0] fx, fz;
  logic [8:0]       fy_diff;
  logic [RGB_W-1:0] rgb;

  assign cfg_ready = 1'b1;

  // Command decode
  assign accept    = start && !busy;
  assign x_ext     = 8'(cell_x);
  assign y_ext     = 8'(cell_y);
  assign h_ext     = 8'(cell_h);
  assign x_in      = x_ext[CW-1:0];
  assign y_in      = y_ext[CW-1:0];
  assign h_in      = h_ext[CW-1:0];
  assign inside_in = (9'(cell_x) < GRID_LIM) && (9'(cell_y) < GRID_LIM) &&
                     (9'(cell_h) < GRID_LIM);
  assign own_addr  = {h_in, y_in, x_in};

  // Sequencer outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    in_clear  = (state == ST_CLEAR);
    in_look   = (state == ST_LOOK);
    in_gather = (state == ST_GATHER);
    in_emit   = (state == ST_EMIT);
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && func == FUNC_CLEAR) state_next = ST_CLEAR;
        else if (accept && func == FUNC_EMIT && inside_in) state_next = ST_LOOK;
      end
      ST_LOOK: begin
        state_next = occ_rd[CIDX_W] ? ST_GATHER : ST_IDLE;
      end
      ST_GATHER: begin
        if (dir == FACE_NZ) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (rest == '0) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Neighbour unit: steps one coordinate by one and flags a step off the grid.
  assign issue_dir = in_look ? FACE_PX : dir + 3'd1;
  assign axis      = issue_dir[2:1];

  always_comb begin
    nb_addr = {ch, cy, cx};
    case (axis)
      AXIS_X:  nb_sel = cx;
      AXIS_H:  nb_sel = ch;
      AXIS_Y:  nb_sel = cy;
      default: nb_sel = cx;
    endcase
    nb_sum     = issue_dir[0] ? 9'(nb_sel) - 9'd1 : 9'(nb_sel) + 9'd1;
    nb_outside = (nb_sum >= GRID_LIM);
    case (axis)
      AXIS_X:  nb_addr = {ch, cy, nb_sum[CW-1:0]};
      AXIS_H:  nb_addr = {nb_sum[CW-1:0], cy, cx};
      AXIS_Y:  nb_addr = {ch, nb_sum[CW-1:0], cx};
      default: nb_addr = {ch, cy, cx};
    endcase
  end

  // Occupancy memory ports: the clearing sweep and inserts share the write port.
  assign occ_we    = in_clear || (accept && func == FUNC_INSERT && inside_in);
  assign occ_waddr = in_clear ? clr_addr : own_addr;
  assign occ_wdata = in_clear ? '0 : {1'b1, color_index};
  assign occ_raddr = busy ? nb_addr : own_addr;

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    occ_rd <= occ_mem[occ_raddr];
  end

  // Palette memory: loads write at acceptance, the emitted cell's colour is read once.
  assign pal_we  = accept && func == FUNC_LOAD && (9'(palette_slot) < PAL_LIM);
  assign cidx_m1 = occ_rd[CIDX_W-1:0] - 8'd1;
  assign pal_hit = (occ_rd[CIDX_W-1:0] != '0) && (9'(cidx_m1) < PAL_LIM);

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[palette_slot[PW-1:0]] <= palette_rgba[RGB_W-1:0];
    end
    if (in_look && pal_hit) begin
      pal_rd <= pal_mem[cidx_m1[PW-1:0]];
    end
  end

  // Face walk: lowest open direction first.
  always_comb begin
    pick = FACE_PX;
    for (int i = FACES - 1; i >= 0; i--) begin
      if (face_mask[i]) pick = 3'(i);
    end
  end

  assign pick_oh   = 6'b000001 << pick;
  assign rest      = face_mask & ~pick_oh;
  assign emit_fire = in_emit && (face_mask != '0);

  // Engine coordinates and colour of the face being sent.
  assign fx      = 9'(cx) - {1'b0, model_size_x[CFG_DATA_W-1:1]};
  assign fz      = 9'(cy) - {1'b0, model_size_y[CFG_DATA_W-1:1]};
  assign fy_diff = 9'(ch) - 9'(least);
  assign rgb     = use_pal ? pal_rd : WHITE;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      least        <= H_TOP;
      vcount       <= '0;
      model_size_x <= SIZE_RESET;
      model_size_y <= SIZE_RESET;
      has_palette  <= 1'b0;
      strobe       <= 1'b0;
      dir          <= FACE_PX;
      face_mask    <= '0;
    end else begin
      state  <= state_next;
      strobe <= emit_fire;

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIZE_X:  model_size_x <= cfg_data;
          CFG_SIZE_Y:  model_size_y <= cfg_data;
          CFG_HAS_PAL: has_palette  <= cfg_data[0];
          default:     ;
        endcase
      end

      // Clearing sweep; the address wraps back to zero at the end.
      if (in_clear) begin
        clr_addr <= clr_addr + AW'(1);
      end

      // Clear and insert bookkeeping
      if (accept && func == FUNC_CLEAR) begin
        least  <= H_TOP;
        vcount <= '0;
      end else if (accept && func == FUNC_INSERT && inside_in && h_in < least) begin
        least <= h_in;
      end

      // Neighbour gathering
      if (in_look) begin
        dir       <= FACE_PX;
        face_mask <= '0;
      end else if (in_gather) begin
        face_mask[dir] <= nb_out || !occ_rd[CIDX_W];
        dir            <= dir + 3'd1;
      end else if (in_emit) begin
        face_mask <= rest;
      end

      if (emit_fire) begin
        vcount <= vcount + VTX_STEP;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    nb_out <= nb_outside;
    if (accept) begin
      cx <= x_in;
      cy <= y_in;
      ch <= h_in;
    end
    if (in_look) begin
      use_pal <= has_palette && pal_hit;
    end
    if (emit_fire) begin
      face_x      <= fx;
      face_y      <= fy_diff[FY_W-1:0];
      face_z      <= fz;
      face_dir    <= pick;
      red         <= rgb[7:0];
      green       <= rgb[15:8];
      blue        <= rgb[23:16];
      base_vertex <= vcount;
      last_face   <= (rest == '0);
    end
  end

endmodule

[hdl/vfcm_checker.sv]
// ---------------------------------------------------------------------------
// vfcm_checker
// Port-level checks on the mesher core: command timing and face bursts.
// ---------------------------------------------------------------------------
`include "voxel_face_culling_mesher_core_macros.svh"

module vfcm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [vfcm_pkg::FUNC_W-1:0]   func,
  input logic                          strobe,
  input logic [vfcm_pkg::DIR_W-1:0]    face_dir,
  input logic [vfcm_pkg::VTX_W-1:0]    base_vertex,
  input logic                          last_face
);
  import vfcm_pkg::*;

  logic cmd_transfer;

  assign cmd_transfer = start && !busy;

  // A face only follows a cycle in which the block was working.
  `VFCM_ASSERT_NOW(a_face_from_work, strobe, $past(busy))

  // Loads and inserts finish in the cycle they are taken.
  `VFCM_ASSERT_NEXT(a_quick_cmds, cmd_transfer && (func == FUNC_LOAD || func == FUNC_INSERT), !busy)

  // A clear starts the sweep and sends nothing.
  `VFCM_ASSERT_NEXT(a_clear_sweeps, cmd_transfer && func == FUNC_CLEAR, busy && !strobe)

  // Faces of one emit come back to back, in rising direction, four vertices apart.
  `VFCM_ASSERT_NEXT(a_face_burst, strobe && !last_face, strobe && face_dir > $past(face_dir) && base_vertex == $past(base_vertex) + VTX_STEP)

endmodule

bind voxel_face_culling_mesher_core vfcm_checker u_vfcm_checker (.*);

[tb/sv/vfcm_face_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vfcm_face_checker
// Watches the command, register and face channels of the voxel mesher. It
// keeps its own occupancy grid, palette and counters, works out the faces
// that each accepted emit should yield and compares every face transfer,
// field by field, with the oldest face still awaited.
// ---------------------------------------------------------------------------
module vfcm_face_checker #(
  parameter int GRID_SIDE       = 32,
  parameter int PALETTE_ENTRIES = 255
) (
  input  logic                                clk,
  input  logic                                rst,
  // Command channel
  input  logic                                start,
  input  logic                                busy,
  input  logic [vfcm_pkg::FUNC_W-1:0]         func,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_x,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_y,
  input  logic [vfcm_pkg::COORD_W-1:0]        cell_h,
  input  logic [vfcm_pkg::CIDX_W-1:0]         color_index,
  input  logic [vfcm_pkg::SLOT_W-1:0]         palette_slot,
  input  logic [vfcm_pkg::RGBA_W-1:0]         palette_rgba,
  // Register channel
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [vfcm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vfcm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Face channel
  input  logic                                strobe,
  input  logic signed [vfcm_pkg::POS_W-1:0]   face_x,
  input  logic [vfcm_pkg::FY_W-1:0]           face_y,
  input  logic signed [vfcm_pkg::POS_W-1:0]   face_z,
  input  logic [vfcm_pkg::DIR_W-1:0]          face_dir,
  input  logic [vfcm_pkg::CH_W-1:0]           red,
  input  logic [vfcm_pkg::CH_W-1:0]           green,
  input  logic [vfcm_pkg::CH_W-1:0]           blue,
  input  logic [vfcm_pkg::VTX_W-1:0]          base_vertex,
  input  logic                                last_face,
  // Totals for the top level
  output int                                  mismatches,
  output int                                  faces_waiting,
  output int                                  faces_checked
);
  import vfcm_pkg::*;

  // Face directions in emit order; H is the source height axis.
  typedef enum logic [DIR_W-1:0] {
    DIR_POS_X = 3'd0,
    DIR_NEG_X = 3'd1,
    DIR_POS_H = 3'd2,
    DIR_NEG_H = 3'd3,
    DIR_POS_Y = 3'd4,
    DIR_NEG_Y = 3'd5
  } dir_e;

  typedef struct packed {
    logic [POS_W-1:0] fx;
    logic [FY_W-1:0]  fy;
    logic [POS_W-1:0] fz;
    logic [DIR_W-1:0] dir;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [VTX_W-1:0] vtx;
    logic             last;
  } face_t;

  // Occupied cells only: a key that exists is an occupied cell, its value
  // is the colour index of the latest insert.
  logic [CIDX_W-1:0]     cell_color [int unsigned];
  logic [RGB_W-1:0]      palette [PALETTE_ENTRIES];
  logic [COORD_W-1:0]    least_h;
  logic [VTX_W-1:0]      vertex_count;
  logic [CFG_DATA_W-1:0] size_x;
  logic [CFG_DATA_W-1:0] size_y;
  logic                  pal_en;
  face_t                 expected_faces [$];
  face_t                 seen;
  face_t                 want;
  int                    n_bad;
  int                    n_checked;

  function automatic bit in_grid(int x, int y, int h);
    return x >= 0 && y >= 0 && h >= 0 && x < GRID_SIDE && y < GRID_SIDE && h < GRID_SIDE;
  endfunction

  function automatic int unsigned cell_key(int x, int y, int h);
    return (h * GRID_SIDE + y) * GRID_SIDE + x;
  endfunction

  // A neighbour outside the grid counts as empty.
  function automatic bit occupied(int x, int y, int h);
    if (!in_grid(x, y, h)) return 1'b0;
    return cell_color.exists(cell_key(x, y, h));
  endfunction

  function automatic void clear_grid();
    cell_color.delete();
    least_h      = COORD_W'(GRID_SIDE - 1);
    vertex_count = '0;
  endfunction

  function automatic string face_text(face_t f);
    return $sformatf("x=%0d y=%0d z=%0d dir=%0d rgb=%02h_%02h_%02h vtx=%0d last=%0b",
                     $signed(f.fx), f.fy, $signed(f.fz), f.dir, f.r, f.g, f.b,
                     f.vtx, f.last);
  endfunction

  task automatic report_mismatch(string msg);
    n_bad++;
    if (n_bad <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Update the grid for one accepted command and queue the faces it yields.
  task automatic predict_command(func_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                 logic [COORD_W-1:0] h, logic [CIDX_W-1:0] cidx,
                                 logic [SLOT_W-1:0] slot, logic [RGBA_W-1:0] rgba);
    face_t            faces [$];
    face_t            f;
    logic [RGB_W-1:0] rgb;
    logic [CIDX_W-1:0] stored;
    int               nx;
    int               ny;
    int               nh;
    dir_e             d;
    case (op)
      FUNC_LOAD: begin
        if (slot < PALETTE_ENTRIES) palette[slot] = rgba[RGB_W-1:0];
      end
      FUNC_CLEAR: begin
        clear_grid();
      end
      FUNC_INSERT: begin
        if (in_grid(x, y, h)) begin
          cell_color[cell_key(x, y, h)] = cidx;
          if (h < least_h) least_h = h;
        end
      end
      FUNC_EMIT: begin
        if (in_grid(x, y, h) && cell_color.exists(cell_key(x, y, h))) begin
          stored = cell_color[cell_key(x, y, h)];
          rgb = WHITE;
          if (pal_en && stored != 0 && stored - 1 < PALETTE_ENTRIES) rgb = palette[stored - 1];
          f.fx = {4'b0, x} - {1'b0, size_x[CFG_DATA_W-1:1]};
          f.fz = {4'b0, y} - {1'b0, size_y[CFG_DATA_W-1:1]};
          f.fy = h - least_h;
          {f.b, f.g, f.r} = rgb;
          for (int i = FACE_PX; i <= FACE_NZ; i++) begin
            d  = dir_e'(i);
            nx = x;
            ny = y;
            nh = h;
            case (d)
              DIR_POS_X: nx++;
              DIR_NEG_X: nx--;
              DIR_POS_H: nh++;
              DIR_NEG_H: nh--;
              DIR_POS_Y: ny++;
              DIR_NEG_Y: ny--;
              default: ;
            endcase
            if (!occupied(nx, ny, nh)) begin
              f.dir  = d;
              f.vtx  = vertex_count;
              f.last = 1'b0;
              faces  = {faces, f};
              vertex_count = vertex_count + VTX_STEP;
            end
          end
          if (faces.size() != 0) faces[faces.size() - 1].last = 1'b1;
          expected_faces = {expected_faces, faces};
        end
      end
      default: ;
    endcase
  endtask

  // All channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst) begin
      clear_grid();
      foreach (palette[i]) palette[i] = '0;
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      pal_en = 1'b0;
      expected_faces.delete();
      n_bad     = 0;
      n_checked = 0;
    end else begin
      // A face transfer is matched against the oldest awaited face.
      if (strobe) begin
        seen = {face_x, face_y, face_z, face_dir, red, green, blue, base_vertex, last_face};
        if (expected_faces.size() == 0) begin
          report_mismatch($sformatf("face with none awaited: %s", face_text(seen)));
        end else begin
          want = expected_faces.pop_front();
          n_checked++;
          if (seen !== want)
            report_mismatch($sformatf("face mismatch: expected %s, got %s",
                                      face_text(want), face_text(seen)));
        end
      end
      // Register writes affect commands accepted in the same cycle and afterwards.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SIZE_X:  size_x = cfg_data;
          CFG_SIZE_Y:  size_y = cfg_data;
          CFG_HAS_PAL: pal_en = cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy)
        predict_command(func_t'(func), cell_x, cell_y, cell_h, color_index,
                        palette_slot, palette_rgba);
    end
    mismatches    <= n_bad;
    faces_waiting <= expected_faces.size();
    faces_checked <= n_checked;
  end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for the voxel face-culling mesher
// Drives a short directed sequence of palette loads, inserts, emits and a
// clear, then random phases under several register settings with inserts
// clustered so that faces are often covered. The face checker predicts and
// compares; this module makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module tb;
  import vfcm_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_ITEMS   = 75;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [FUNC_W-1:0]       func = FUNC_LOAD;
  logic [COORD_W-1:0]      cell_x = '0;
  logic [COORD_W-1:0]      cell_y = '0;
  logic [COORD_W-1:0]      cell_h = '0;
  logic [CIDX_W-1:0]       color_index = '0;
  logic [SLOT_W-1:0]       palette_slot = '0;
  logic [RGBA_W-1:0]       palette_rgba = '0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SIZE_X;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    strobe;
  logic signed [POS_W-1:0] face_x;
  logic [FY_W-1:0]         face_y;
  logic signed [POS_W-1:0] face_z;
  logic [DIR_W-1:0]        face_dir;
  logic [CH_W-1:0]         red;
  logic [CH_W-1:0]         green;
  logic [CH_W-1:0]         blue;
  logic [VTX_W-1:0]        base_vertex;
  logic                    last_face;
  int                      mismatches;
  int                      faces_waiting;
  int                      faces_checked;

  int unsigned             cycles = 0;
  int                      n_sent = 0;
  int                      n_emits = 0;
  int                      n_settings = 0;
  bit                      burst = 1'b0;
  int                      loaded_slots [$];
  logic [3*COORD_W-1:0]    cells [$];

  voxel_face_culling_mesher_core dut (.*);

  vfcm_face_checker checker_i (.*);

  // Clock and cycle counter.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles", CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Idle gap before the next command; stretches of back-to-back transfers
  // alternate with stretches of random gaps.
  function automatic int next_gap();
    if ($urandom_range(0, 15) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // Inserts only use white or a colour whose palette entry has been loaded.
  function automatic logic [31:0] pick_color();
    if (loaded_slots.size() == 0 || $urandom_range(0, 3) == 0) return 0;
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)] + 1;
  endfunction

  function automatic int pick_base();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 28;
      default: return $urandom_range(0, 28);
    endcase
  endfunction

  // One command transfer. Start stays high across back-to-back commands.
  task automatic send_command(func_t op, logic [31:0] x, logic [31:0] y, logic [31:0] h,
                              logic [31:0] c, logic [31:0] slot, logic [31:0] rgba);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= op;
    cell_x       <= x[COORD_W-1:0];
    cell_y       <= y[COORD_W-1:0];
    cell_h       <= h[COORD_W-1:0];
    color_index  <= c[CIDX_W-1:0];
    palette_slot <= slot[SLOT_W-1:0];
    palette_rgba <= rgba;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    case (op)
      FUNC_EMIT:  n_emits++;
      FUNC_CLEAR: cells.delete();
      FUNC_LOAD: begin
        if (slot[SLOT_W-1:0] < 255 && !(slot[SLOT_W-1:0] inside {loaded_slots}))
          loaded_slots = {loaded_slots, int'(slot[SLOT_W-1:0])};
      end
      default: ;
    endcase
  endtask

  // Wait until every awaited face has come and the block has gone idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (faces_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_settings(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                                logic pal);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_SIZE_X, CFG_SIZE_Y, CFG_HAS_PAL};
    val = '{sx, sy, {8'b0, pal}};
    settle();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // A random phase: a clear, then loads, clustered inserts and emits that
  // mostly target occupied cells, with some noise across the whole grid.
  task automatic run_phase(int n_items);
    int                 base_x;
    int                 base_y;
    int                 base_h;
    int                 roll;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] h;
    logic [SLOT_W-1:0]  slot;
    base_x = pick_base();
    base_y = pick_base();
    base_h = pick_base();
    send_command(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int i = 1; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      h = COORD_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        x = COORD_W'(base_x + $urandom_range(0, 3));
        y = COORD_W'(base_y + $urandom_range(0, 3));
        h = COORD_W'(base_h + $urandom_range(0, 3));
      end
      if (roll < 10) begin
        slot = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 254));
        send_command(FUNC_LOAD, 32'(x), 32'(y), 32'(h), $urandom, 32'(slot), $urandom);
      end else if (roll < 50) begin
        send_command(FUNC_INSERT, 32'(x), 32'(y), 32'(h), pick_color(), $urandom, $urandom);
        cells = {cells, {h, y, x}};
      end else begin
        if (cells.size() != 0 && $urandom_range(0, 3) != 0)
          {h, y, x} = cells[$urandom_range(0, cells.size() - 1)];
        send_command(FUNC_EMIT, 32'(x), 32'(y), 32'(h), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the palette in use.
    write_settings(9'd32, 9'd32, 1'b1);
    send_command(FUNC_LOAD, 0, 0, 0, 0, 0, 32'hC0332211);
    send_command(FUNC_LOAD, 0, 0, 0, 0, 254, 32'hFFFFFFFF);
    send_command(FUNC_LOAD, 0, 0, 0, 0, 255, 32'h00000000);
    send_command(FUNC_INSERT, 0, 0, 0, 255, 0, 0);
    send_command(FUNC_INSERT, 31, 31, 31, 1, 0, 0);
    send_command(FUNC_INSERT, 1, 0, 0, 0, 0, 0);
    // The later insert on the same cell decides its colour.
    send_command(FUNC_INSERT, 0, 0, 0, 1, 0, 0);
    send_command(FUNC_INSERT, 15, 16, 10, 255, 0, 0);
    send_command(FUNC_EMIT, 0, 0, 0, 0, 0, 0);
    send_command(FUNC_EMIT, 31, 31, 31, 0, 0, 0);
    send_command(FUNC_EMIT, 1, 0, 0, 0, 0, 0);
    send_command(FUNC_EMIT, 5, 5, 5, 0, 0, 0);
    send_command(FUNC_EMIT, 15, 16, 10, 0, 0, 0);
    // A cell with all six neighbours present yields no face.
    send_command(FUNC_INSERT, 21, 20, 20, 1, 0, 0);
    send_command(FUNC_INSERT, 19, 20, 20, 1, 0, 0);
    send_command(FUNC_INSERT, 20, 21, 20, 255, 0, 0);
    send_command(FUNC_INSERT, 20, 19, 20, 255, 0, 0);
    send_command(FUNC_INSERT, 20, 20, 21, 0, 0, 0);
    send_command(FUNC_INSERT, 20, 20, 19, 0, 0, 0);
    send_command(FUNC_INSERT, 20, 20, 20, 1, 0, 0);
    send_command(FUNC_EMIT, 20, 20, 20, 0, 0, 0);
    send_command(FUNC_EMIT, 20, 21, 20, 0, 0, 0);
    // After a clear the grid is empty and the counters start again.
    send_command(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
    send_command(FUNC_EMIT, 0, 0, 0, 0, 0, 0);
    send_command(FUNC_INSERT, 2, 3, 4, 1, 0, 0);
    send_command(FUNC_EMIT, 2, 3, 4, 0, 0, 0);

    // Random phases under a range of register settings.
    write_settings(9'd0, 9'd256, 1'b1);
    run_phase(PHASE_ITEMS);
    write_settings(9'd256, 9'd0, 1'b0);
    run_phase(PHASE_ITEMS);
    write_settings(9'd255, 9'd1, 1'b1);
    run_phase(PHASE_ITEMS);
    write_settings(9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)), 1'b1);
    run_phase(PHASE_ITEMS);
    write_settings(9'd32, 9'd32, 1'b0);
    run_phase(PHASE_ITEMS);

    settle();
    $display("Ran %0d commands, %0d of them emits, under %0d register settings.",
             n_sent, n_emits, n_settings);
    $display("Checked %0d face transfers; %0d mismatches, %0d faces never arrived.",
             faces_checked, mismatches, faces_waiting);
    if (mismatches == 0 && faces_waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/vfcm_pkg.sv
hdl/voxel_face_culling_mesher_core.sv
hdl/vfcm_checker.sv
tb/sv/vfcm_face_checker.sv
tb/sv/tb.sv
